// ===== rtl/core/aoc_pkg.sv =====
// Package with the AVR opcode mask/pattern tables, entry indexes and result type.
`default_nettype none

package aoc_pkg;

  localparam int unsigned EntryCount = 131;
  localparam int unsigned WordWidth  = 16;
  localparam int unsigned IdWidth    = 8;

  // Table positions of the four instructions that carry a second word.
  localparam int unsigned JmpIndex   = 10;
  localparam int unsigned CallIndex  = 80;
  localparam int unsigned Sts32Index = 56;
  localparam int unsigned Lds32Index = 58;

  // Opcode masks in priority order.
  localparam logic [WordWidth-1:0] MaskTable [EntryCount] = '{
    16'hffff, 16'hff00, 16'hfc00, 16'hff00, 16'hff88, 16'hff88, 16'hff88, 16'hff88,
    16'hf000, 16'hf000, 16'hfe0e, 16'hffff, 16'hfc00, 16'hfe0f, 16'hfe0f, 16'hfc00,
    16'hfc00, 16'hff00, 16'hfc00, 16'hf000, 16'hfc00, 16'hf000, 16'hff00, 16'hfe0f,
    16'hfe0f, 16'hf800, 16'hf800, 16'hff00, 16'hff00, 16'hfe08, 16'hfe08, 16'hfc00,
    16'hfc00, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hd208,
    16'hd208, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f,
    16'hfe0f, 16'hfe0f, 16'hd208, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hd208, 16'hf800,
    16'hfe0f, 16'hf800, 16'hfe0f, 16'hfe0f, 16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07,
    16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07,
    16'hfc07, 16'hfc07, 16'hfc07, 16'hfc07, 16'hf000, 16'hffff, 16'hffff, 16'hffff,
    16'hfe0e, 16'hfc00, 16'hf000, 16'hfc00, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f,
    16'hf000, 16'hfc00, 16'hfc00, 16'hf000, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f,
    16'hfe0f, 16'hfe08, 16'hfe08, 16'hff00, 16'hff00, 16'hffff, 16'hfe0f, 16'hfe0f,
    16'hffff, 16'hffff, 16'hffff, 16'hfe0f, 16'hfe0f, 16'hff0f, 16'hffff, 16'hffff,
    16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
    16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
    16'hffff, 16'hffff, 16'hffff
  };

  // Opcode patterns in priority order.
  localparam logic [WordWidth-1:0] ValueTable [EntryCount] = '{
    16'h0000, 16'h0100, 16'h9c00, 16'h0200, 16'h0300, 16'h0308, 16'h0380, 16'h0388,
    16'he000, 16'hc000, 16'h940c, 16'h9409, 16'h2c00, 16'h940a, 16'h9403, 16'h0c00,
    16'h1c00, 16'h9600, 16'h1800, 16'h5000, 16'h0800, 16'h4000, 16'h9700, 16'h920f,
    16'h900f, 16'hb000, 16'hb800, 16'h9b00, 16'h9900, 16'hfc00, 16'hfe00, 16'h1000,
    16'h2400, 16'h900c, 16'h900d, 16'h900e, 16'h8008, 16'h9009, 16'h900a, 16'h8008,
    16'h8000, 16'h8000, 16'h9001, 16'h9002, 16'h920c, 16'h920d, 16'h920e, 16'h8208,
    16'h9209, 16'h920a, 16'h8208, 16'h8200, 16'h9201, 16'h9202, 16'h8200, 16'ha800,
    16'h9200, 16'ha000, 16'h9000, 16'h9204, 16'hf401, 16'hf001, 16'hf404, 16'hf402,
    16'hf000, 16'hf004, 16'hf400, 16'hf003, 16'hf006, 16'hf406, 16'hf002, 16'hf405,
    16'hf005, 16'hf407, 16'hf007, 16'hf403, 16'hd000, 16'h9508, 16'h9518, 16'h9509,
    16'h940e, 16'h1400, 16'h3000, 16'h0400, 16'h9406, 16'h9405, 16'h9407, 16'h9402,
    16'h6000, 16'h2800, 16'h2000, 16'h7000, 16'h9205, 16'h9206, 16'h9207, 16'h9400,
    16'h9401, 16'hf800, 16'hfa00, 16'h9a00, 16'h9800, 16'h95c8, 16'h9004, 16'h9005,
    16'h9519, 16'h9419, 16'h95d8, 16'h9006, 16'h9007, 16'h940b, 16'h9588, 16'h95a8,
    16'h9598, 16'h95e8, 16'h95f8, 16'h9448, 16'h9468, 16'h9438, 16'h9418, 16'h9458,
    16'h9408, 16'h9478, 16'h9428, 16'h94c8, 16'h94e8, 16'h94b8, 16'h9498, 16'h94d8,
    16'h9488, 16'h94f8, 16'h94a8
  };

  // Classification result of one instruction word.
  typedef struct packed {
    logic [IdWidth-1:0] instruction_id;
    logic               match_found;
    logic               two_word;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/avr_opcode_classifier_unit.sv =====
// Top level of the AVR opcode classifier: input register, matcher and result register.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ------------------------------------------------
//   in       in_valid_i / in_ready_o   instruction_word_i[15:0]
//   out      out_valid_o / out_ready_i instruction_id_o[7:0], match_found_o, two_word_o
//
// A word is captured in the input register, classified in the following cycle by
// the mask compares and priority encoder, and held in the result register.
// Throughput is one word per cycle while out_ready_i does not stall the output; the
// result is valid once the word has moved from the input register into the result register.
// Reset clears only the two valid flags; the payload registers are not reset.
// When out_ready_i is low the result register holds and the input stage holds
// behind it, so at most two words are in flight.
`default_nettype none

module avr_opcode_classifier_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] instruction_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       instruction_id_o,
  output logic             match_found_o,
  output logic             two_word_o
);

  logic                              in_valid_q, in_valid_d;
  logic [aoc_pkg::WordWidth-1:0]     word_q;
  logic                              out_valid_q, out_valid_d;
  aoc_pkg::result_t                  result_q;
  aoc_pkg::result_t                  result_d;
  logic                              out_advance;
  logic                              in_advance;

  // Stage handshakes: each register moves when it is empty or its word leaves.
  assign out_advance = !out_valid_q || out_ready_i;
  assign in_advance  = !in_valid_q || out_advance;
  assign in_ready_o  = in_advance;

  assign in_valid_d  = in_advance ? in_valid_i : in_valid_q;
  assign out_valid_d = out_advance ? in_valid_q : out_valid_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (in_advance && in_valid_i) begin
      word_q <= instruction_word_i;
    end
  end

  aoc_decode u_decode (
    .word_i   (word_q),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign instruction_id_o = result_q.instruction_id;
  assign match_found_o    = result_q.match_found;
  assign two_word_o       = result_q.two_word;

endmodule

`default_nettype wire

// ===== rtl/core/aoc_decode.sv =====
// Combinational opcode matcher: parallel mask compares and a priority encoder.
`default_nettype none

module aoc_decode (
  input  wire logic [aoc_pkg::WordWidth-1:0] word_i,
  output aoc_pkg::result_t                   result_o
);

  logic [aoc_pkg::EntryCount-1:0] hit;

  // Compare the word against every table entry at once.
  always_comb begin
    for (int i = 0; i < aoc_pkg::EntryCount; i++) begin
      hit[i] = ((word_i & aoc_pkg::MaskTable[i]) == aoc_pkg::ValueTable[i]);
    end
  end

  // The lowest matching entry wins; scan from the top so it is assigned last.
  always_comb begin
    result_o.instruction_id = '0;
    result_o.match_found    = 1'b0;
    for (int i = aoc_pkg::EntryCount - 1; i >= 0; i--) begin
      if (hit[i]) begin
        result_o.instruction_id = aoc_pkg::IdWidth'(i);
        result_o.match_found    = 1'b1;
      end
    end
    result_o.two_word = hit[aoc_pkg::JmpIndex] | hit[aoc_pkg::CallIndex] |
                        hit[aoc_pkg::Sts32Index] | hit[aoc_pkg::Lds32Index];
  end

endmodule

`default_nettype wire
